>>> rtl/core/alm_pkg.sv
// Shared types and codes for the array linked list manager.
// Holds request codes, status codes, the controller state type and the cell operation type.
// No dependencies.
`timescale 1ns / 1ps

package alm_pkg;

    localparam int DATA_W   = 32;
    localparam int KIND_W   = 2;
    localparam int PLACE_W  = 2;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;
    localparam int OUT_MAX  = 16;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

    localparam logic [PLACE_W-1:0] PLACE_HEAD = 2'd0;
    localparam logic [PLACE_W-1:0] PLACE_POS  = 2'd1;
    localparam logic [PLACE_W-1:0] PLACE_TAIL = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_BADPOS    = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS,
        ST_ROT,
        ST_CMP,
        ST_RESP
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ROTATE,
        CELL_COMPACT
    } cell_op_t;

endpackage

>>> rtl/core/array_linked_list_manager_core.sv
// Top level of the array linked list manager: a chain of element cells in list order.
// Depends on alm_pkg, alm_cell and alm_ctrl.
`timescale 1ns / 1ps

// Usage
// A request item enters on the s_ channel; its results leave on the m_ channel, the last
// result of each request marked by m_tlast. Insert and error requests give one result;
// delete gives one result carrying the removed element; read-out gives one result per
// element in list order, up to sixteen, or one list-empty result.
// The elements sit in a row of NODES cells in list order. Insert shifts the cells behind
// the insertion point one place back. Delete and read-out rotate the whole row once through
// cell 0, one cell per cycle unless a read-out waits on the receiver, and delete then closes
// the gap. A new request is taken once the previous one has left the sequencer; for delete
// and read-out the rotation of the cell row holds the next request back.
// A result register separates the two sides. When the receiver stalls, the rotation of a
// read-out pauses until the waiting element is taken; other requests wait for the slot.
// After reset the list is empty and the count is zero.

module array_linked_list_manager_core #(
    parameter int NODES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // position [4:0], value [36:5], zero [39:37]
    input  logic [3:0]  s_tuser,  // kind [1:0], place [3:2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // data [31:0], count [36:32], zero [39:37]
    output logic [2:0]  m_tuser,  // status [2:0]
    output logic        m_tlast
);

    localparam int CW = $clog2(NODES + 1);

    logic [alm_pkg::DATA_W-1:0]   cell_val [NODES];
    alm_pkg::cell_op_t            cell_op;
    logic [CW-1:0]                cell_target;
    logic [alm_pkg::DATA_W-1:0]   cell_new;
    logic [alm_pkg::DATA_W-1:0]   m_data;
    logic [alm_pkg::COUNT_W-1:0]  m_count;

    alm_ctrl #(
        .NODES (NODES),
        .CW    (CW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .kind        (s_tuser[1:0]),
        .place       (s_tuser[3:2]),
        .position    (s_tdata[4:0]),
        .value       (s_tdata[36:5]),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_status    (m_tuser),
        .m_data      (m_data),
        .m_count     (m_count),
        .m_last      (m_tlast),
        .cell_op     (cell_op),
        .cell_target (cell_target),
        .cell_new    (cell_new),
        .head_val    (cell_val[0])
    );

    for (genvar i = 0; i < NODES; i++) begin : g_cell
        logic [alm_pkg::DATA_W-1:0] left_val;
        if (i == 0) begin : g_first
            assign left_val = cell_new;
        end else begin : g_rest
            assign left_val = cell_val[i-1];
        end
        alm_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .aclk      (aclk),
            .op        (cell_op),
            .target    (cell_target),
            .left_val  (left_val),
            .right_val (cell_val[(i + 1) % NODES]),
            .new_val   (cell_new),
            .val       (cell_val[i])
        );
    end

    assign m_tdata = {3'b000, m_count, m_data};

endmodule

>>> rtl/core/alm_cell.sv
// One storage cell of the list chain: holds the element at its place in list order.
// Depends on alm_pkg for the cell operation type.
`timescale 1ns / 1ps

module alm_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic                     aclk,
    input  alm_pkg::cell_op_t        op,
    input  logic [CW-1:0]            target,
    input  logic [alm_pkg::DATA_W-1:0] left_val,
    input  logic [alm_pkg::DATA_W-1:0] right_val,
    input  logic [alm_pkg::DATA_W-1:0] new_val,
    output logic [alm_pkg::DATA_W-1:0] val
);

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic [alm_pkg::DATA_W-1:0] val_reg;

    always_ff @(posedge aclk) begin
        case (op)
            alm_pkg::CELL_INSERT: begin
                // Cells behind the insertion point move one place back.
                if (MY_IDX > target) begin
                    val_reg <= left_val;
                end else if (MY_IDX == target) begin
                    val_reg <= new_val;
                end
            end
            alm_pkg::CELL_ROTATE: begin
                val_reg <= right_val;
            end
            alm_pkg::CELL_COMPACT: begin
                if (MY_IDX >= target) begin
                    val_reg <= right_val;
                end
            end
            default: begin
                val_reg <= val_reg;
            end
        endcase
    end

    assign val = val_reg;

endmodule

>>> rtl/core/alm_ctrl.sv
// Request decoder, sequencer and result register of the array linked list manager.
// Depends on alm_pkg; drives the operation of the cell chain and watches cell 0.
`timescale 1ns / 1ps

module alm_ctrl #(
    parameter int NODES = 16,
    parameter int CW    = 5
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [alm_pkg::KIND_W-1:0]    kind,
    input  logic [alm_pkg::PLACE_W-1:0]   place,
    input  logic [alm_pkg::POS_W-1:0]     position,
    input  logic [alm_pkg::DATA_W-1:0]    value,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [alm_pkg::STATUS_W-1:0]  m_status,
    output logic [alm_pkg::DATA_W-1:0]    m_data,
    output logic [alm_pkg::COUNT_W-1:0]   m_count,
    output logic                          m_last,
    output alm_pkg::cell_op_t             cell_op,
    output logic [CW-1:0]                 cell_target,
    output logic [alm_pkg::DATA_W-1:0]    cell_new,
    input  logic [alm_pkg::DATA_W-1:0]    head_val
);

    localparam int CMP_W = ((CW > alm_pkg::POS_W) ? CW : alm_pkg::POS_W) + 1;
    localparam logic [CW-1:0]    STEP_END = CW'(NODES - 1);
    localparam logic [CMP_W-1:0] FULL_CNT = CMP_W'(NODES);
    localparam logic [CMP_W-1:0] OUT_CNT  = CMP_W'(alm_pkg::OUT_MAX);

    alm_pkg::state_t state_reg, state_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [CW-1:0]                  step_reg, step_next;
    logic [CW-1:0]                  target_reg, target_next;
    logic [CW-1:0]                  last_step_reg, last_step_next;
    logic [alm_pkg::KIND_W-1:0]     kind_reg, kind_next;
    logic [alm_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic [alm_pkg::DATA_W-1:0]     data_reg, data_next;
    logic [alm_pkg::DATA_W-1:0]     value_reg, value_next;

    logic                           m_tvalid_reg, m_tvalid_next;
    logic [alm_pkg::STATUS_W-1:0]   m_status_reg, m_status_next;
    logic [alm_pkg::DATA_W-1:0]     m_data_reg, m_data_next;
    logic [alm_pkg::COUNT_W-1:0]    m_count_reg, m_count_next;
    logic                           m_last_reg, m_last_next;

    alm_pkg::state_t                dec_state;
    logic [alm_pkg::STATUS_W-1:0]   dec_status;
    logic [CW-1:0]                  dec_target;
    logic [CW-1:0]                  dec_last_step;
    logic [CMP_W-1:0]               pos_w;
    logic [CMP_W-1:0]               cnt_w;

    logic accept;
    logic out_free;
    logic need_out;
    logic advance;
    logic load_out;

    assign accept   = (state_reg == alm_pkg::ST_IDLE) && s_tvalid;
    assign out_free = !m_tvalid_reg || m_tready;
    // During a read-out the chain only moves while an element is not waiting for the output.
    assign need_out = (kind_reg == alm_pkg::KIND_READ) && (step_reg <= last_step_reg);
    assign advance  = !need_out || out_free;

    assign pos_w = CMP_W'(position);
    assign cnt_w = CMP_W'(count_reg);

    // Request checks against the current count.
    always_comb begin
        dec_state     = alm_pkg::ST_RESP;
        dec_status    = alm_pkg::STAT_OK;
        dec_target    = '0;
        dec_last_step = '0;
        case (place)
            alm_pkg::PLACE_HEAD: dec_target = '0;
            alm_pkg::PLACE_POS:  dec_target = CW'(pos_w - CMP_W'(1));
            default: begin
                if (kind == alm_pkg::KIND_INSERT) begin
                    dec_target = count_reg;
                end else begin
                    dec_target = count_reg - CW'(1);
                end
            end
        endcase
        case (kind)
            alm_pkg::KIND_INSERT: begin
                if (cnt_w == FULL_CNT) begin
                    dec_status = alm_pkg::STAT_OVERFLOW;
                end else if (place != alm_pkg::PLACE_HEAD && place != alm_pkg::PLACE_POS
                             && place != alm_pkg::PLACE_TAIL) begin
                    dec_status = alm_pkg::STAT_BADPOS;
                end else if (place == alm_pkg::PLACE_POS
                             && (pos_w == '0 || pos_w > cnt_w + CMP_W'(1))) begin
                    dec_status = alm_pkg::STAT_BADPOS;
                end else begin
                    dec_state = alm_pkg::ST_INS;
                end
            end
            alm_pkg::KIND_DELETE: begin
                if (cnt_w == '0) begin
                    dec_status = alm_pkg::STAT_UNDERFLOW;
                end else if (place != alm_pkg::PLACE_HEAD && place != alm_pkg::PLACE_POS
                             && place != alm_pkg::PLACE_TAIL) begin
                    dec_status = alm_pkg::STAT_BADPOS;
                end else if (place == alm_pkg::PLACE_POS
                             && (pos_w == '0 || pos_w > cnt_w)) begin
                    dec_status = alm_pkg::STAT_BADPOS;
                end else begin
                    dec_state = alm_pkg::ST_ROT;
                end
            end
            alm_pkg::KIND_READ: begin
                if (cnt_w == '0) begin
                    dec_status = alm_pkg::STAT_EMPTY;
                end else begin
                    dec_state = alm_pkg::ST_ROT;
                end
            end
            default: begin
                dec_status = alm_pkg::STAT_BADPOS;
            end
        endcase
        // At most OUT_MAX elements are read out.
        if (cnt_w >= OUT_CNT) begin
            dec_last_step = CW'(alm_pkg::OUT_MAX - 1);
        end else begin
            dec_last_step = count_reg - CW'(1);
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            alm_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = dec_state;
                end
            end
            alm_pkg::ST_INS: begin
                state_next = alm_pkg::ST_RESP;
            end
            alm_pkg::ST_ROT: begin
                if (advance && step_reg == STEP_END) begin
                    if (kind_reg == alm_pkg::KIND_DELETE) begin
                        state_next = alm_pkg::ST_CMP;
                    end else begin
                        state_next = alm_pkg::ST_IDLE;
                    end
                end
            end
            alm_pkg::ST_CMP: begin
                state_next = alm_pkg::ST_RESP;
            end
            alm_pkg::ST_RESP: begin
                if (out_free) begin
                    state_next = alm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = alm_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath.
    always_comb begin
        count_next     = count_reg;
        step_next      = step_reg;
        target_next    = target_reg;
        last_step_next = last_step_reg;
        kind_next      = kind_reg;
        status_next    = status_reg;
        data_next      = data_reg;
        value_next     = value_reg;
        cell_op        = alm_pkg::CELL_HOLD;
        load_out       = 1'b0;
        m_status_next  = m_status_reg;
        m_data_next    = m_data_reg;
        m_count_next   = m_count_reg;
        m_last_next    = m_last_reg;
        case (state_reg)
            alm_pkg::ST_IDLE: begin
                if (accept) begin
                    kind_next      = kind;
                    status_next    = dec_status;
                    target_next    = dec_target;
                    last_step_next = dec_last_step;
                    value_next     = value;
                    data_next      = '0;
                    step_next      = '0;
                end
            end
            alm_pkg::ST_INS: begin
                cell_op    = alm_pkg::CELL_INSERT;
                count_next = count_reg + CW'(1);
            end
            alm_pkg::ST_ROT: begin
                if (advance) begin
                    // After step rotations, cell 0 holds the element at list index step.
                    cell_op   = alm_pkg::CELL_ROTATE;
                    step_next = step_reg + CW'(1);
                    if (kind_reg == alm_pkg::KIND_DELETE && step_reg == target_reg) begin
                        data_next = head_val;
                    end
                    if (need_out) begin
                        load_out      = 1'b1;
                        m_status_next = alm_pkg::STAT_OK;
                        m_data_next   = head_val;
                        m_count_next  = alm_pkg::COUNT_W'(count_reg);
                        m_last_next   = (step_reg == last_step_reg);
                    end
                end
            end
            alm_pkg::ST_CMP: begin
                cell_op    = alm_pkg::CELL_COMPACT;
                count_next = count_reg - CW'(1);
            end
            alm_pkg::ST_RESP: begin
                if (out_free) begin
                    load_out      = 1'b1;
                    m_status_next = status_reg;
                    m_data_next   = data_reg;
                    m_count_next  = alm_pkg::COUNT_W'(count_reg);
                    m_last_next   = 1'b1;
                end
            end
            default: begin
                cell_op = alm_pkg::CELL_HOLD;
            end
        endcase
        if (load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= alm_pkg::ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg      <= step_next;
        target_reg    <= target_next;
        last_step_reg <= last_step_next;
        kind_reg      <= kind_next;
        status_reg    <= status_next;
        data_reg      <= data_next;
        value_reg     <= value_next;
        m_status_reg  <= m_status_next;
        m_data_reg    <= m_data_next;
        m_count_reg   <= m_count_next;
        m_last_reg    <= m_last_next;
    end

    assign s_tready    = (state_reg == alm_pkg::ST_IDLE);
    assign m_tvalid    = m_tvalid_reg;
    assign m_status    = m_status_reg;
    assign m_data      = m_data_reg;
    assign m_count     = m_count_reg;
    assign m_last      = m_last_reg;
    assign cell_target = target_reg;
    assign cell_new    = value_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(count_reg) <= FULL_CNT)
        else $error("element count exceeds the node store");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == alm_pkg::ST_INS) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not add one element");

    a_compact_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == alm_pkg::ST_CMP) |-> (count_reg != '0))
        else $error("compaction on an empty list");

    a_rot_emit_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == alm_pkg::ST_ROT && load_out) |-> (kind_reg == alm_pkg::KIND_READ))
        else $error("element emitted during a rotation that is not a read-out");

    a_accept_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_out && state_reg == alm_pkg::ST_RESP) |=> (state_reg == alm_pkg::ST_IDLE))
        else $error("single result not followed by return to idle");

endmodule
